FILE: rtl/multi_queue_deque_engine_core_assert.svh
// assertion macros for the deque engine checker
`ifndef MULTI_QUEUE_DEQUE_ENGINE_CORE_ASSERT_SVH
`define MULTI_QUEUE_DEQUE_ENGINE_CORE_ASSERT_SVH

// same-cycle implication
`define MQDE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MQDE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/mqde_pkg.sv
// shared types and constants for the multi-queue deque engine
package mqde_pkg;

  localparam int NUM_QUEUES_DEF = 8;
  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [2:0] {
    CMD_CLAIM     = 3'd0,
    CMD_RELEASE   = 3'd1,
    CMD_PUSH_TAIL = 3'd2,
    CMD_PUSH_HEAD = 3'd3,
    CMD_POP_HEAD  = 3'd4,
    CMD_REM_MATCH = 3'd5,
    CMD_REM_AT    = 3'd6,
    CMD_READ_AT   = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NO_FREE     = 3'd1,
    ST_NOT_CLAIMED = 3'd2,
    ST_EMPTY       = 3'd3,
    ST_NOT_FOUND   = 3'd4,
    ST_RANGE       = 3'd5,
    ST_FULL        = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    CO_HOLD,
    CO_PUSH_TAIL,
    CO_PUSH_HEAD,
    CO_CLOSE_AT,
    CO_CLOSE_MATCH
  } cell_op_e;

  typedef struct packed {
    logic     en;
    cell_op_e op;
  } cell_ctl_t;

endpackage

FILE: rtl/mqde_cell.sv
// one entry cell of a queue row, shifting toward head or tail
module mqde_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int CW         = 5,
  parameter int XW         = 5,
  parameter int K          = 0
) (
  input  logic                  clk,
  input  mqde_pkg::cell_ctl_t   ctl,
  input  logic [DATA_WIDTH-1:0] val,
  input  logic [XW-1:0]         pos,
  input  logic [CW-1:0]         cnt,
  input  logic [DATA_WIDTH-1:0] prev_data,
  input  logic [DATA_WIDTH-1:0] next_data,
  input  logic                  hit_in,
  output logic [DATA_WIDTH-1:0] data,
  output logic                  hit_out
);
  import mqde_pkg::*;

  localparam logic [XW-1:0] KX = XW'(K);
  localparam logic [CW-1:0] KC = CW'(K);

  logic                  hit;
  logic [DATA_WIDTH-1:0] data_next;

  assign hit     = (KC < cnt) && (data == val);
  assign hit_out = hit_in | hit;

  always_comb begin
    data_next = data;
    if (ctl.en) begin
      case (ctl.op)
        CO_PUSH_TAIL: if (KC == cnt) data_next = val;
        CO_PUSH_HEAD: data_next = prev_data;
        CO_CLOSE_AT: if (KX >= pos) data_next = next_data;
        CO_CLOSE_MATCH: if (hit_out) data_next = next_data;
        default: data_next = data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

FILE: rtl/multi_queue_deque_engine_core.sv
// top level: command decode, queue bookkeeping and the rows of entry cells
// an accepted start beat sets busy; the busy (work) cycle then registers done
// and the result fields. A new command is taken only while not busy; the work
// cycle does the cell update, with its ripple match chain along each queue row
// the receiver cannot stall: done flags each result for exactly one cycle
// reset clears busy, done, queue counts and claims; entry words are not cleared
module multi_queue_deque_engine_core #(
  parameter int NUM_QUEUES = mqde_pkg::NUM_QUEUES_DEF,
  parameter int DEPTH      = mqde_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = mqde_pkg::DATA_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command,
  input  logic [2:0]  queue_id,
  input  logic [31:0] value,
  input  logic [3:0]  index,
  output logic        done,
  output logic [2:0]  status,
  output logic [31:0] value_out,
  output logic [2:0]  queue_out,
  output logic [4:0]  count
);
  import mqde_pkg::*;

  localparam int CW  = $clog2(DEPTH + 1);
  localparam int XW  = (CW > 4) ? CW : 4;
  localparam int QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int DAW = $clog2(DEPTH);

  // registered command
  cmd_e                  cmd_r;
  logic [2:0]            q_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic [3:0]            idx_r;

  logic [CW-1:0] qcount      [NUM_QUEUES];
  logic [CW-1:0] qcount_next [NUM_QUEUES];
  logic [NUM_QUEUES-1:0] claimed, claimed_next;

  logic [DATA_WIDTH-1:0] cdata [NUM_QUEUES][DEPTH];
  logic                  chit  [NUM_QUEUES][DEPTH];
  cell_ctl_t             qctl  [NUM_QUEUES];

  logic [QW+2:0]   qtmp;
  logic [QW-1:0]   qidx;
  logic            in_range;
  logic            qok;
  logic [CW-1:0]   n;
  logic [XW-1:0]   n_x, idx_x, pos_x;
  logic [DAW-1:0]  aidx;
  logic            found;
  logic            free_found;
  logic [QW-1:0]   free_idx;
  cell_op_e        op;
  logic            do_op;
  status_e         st;
  logic [DATA_WIDTH-1:0] vout;
  logic [2:0]      qout;
  logic [CW-1:0]   cnt_after;

  always_comb begin
    qtmp     = (QW+3)'(q_r);
    qidx     = qtmp[QW-1:0];
    in_range = qtmp < (QW+3)'(NUM_QUEUES);
    qok      = in_range && claimed[qidx];
    n        = qcount[qidx];
    n_x      = XW'(n);
    idx_x    = XW'(idx_r);
    pos_x    = (cmd_r == CMD_POP_HEAD) ? '0 : idx_x;
    aidx     = DAW'(pos_x);
    found    = chit[qidx][DEPTH-1];
  end

  // lowest free queue
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
      if (!claimed[i]) begin
        free_found = 1'b1;
        free_idx   = QW'(i);
      end
    end
  end

  always_comb begin
    st           = ST_OK;
    vout         = '0;
    op           = CO_HOLD;
    do_op        = 1'b0;
    qout         = q_r;
    claimed_next = claimed;
    for (int i = 0; i < NUM_QUEUES; i++) qcount_next[i] = qcount[i];
    if (cmd_r == CMD_CLAIM) begin
      qout = 3'(free_idx);
      if (free_found) begin
        claimed_next[free_idx] = 1'b1;
        qcount_next[free_idx]  = '0;
      end else begin
        st   = ST_NO_FREE;
        qout = '0;
      end
    end else if (!qok) begin
      st = ST_NOT_CLAIMED;
    end else begin
      case (cmd_r)
        CMD_RELEASE: begin
          claimed_next[qidx] = 1'b0;
          qcount_next[qidx]  = '0;
        end
        CMD_PUSH_TAIL, CMD_PUSH_HEAD: begin
          if (n == CW'(DEPTH)) begin
            st = ST_FULL;
          end else begin
            op    = (cmd_r == CMD_PUSH_TAIL) ? CO_PUSH_TAIL : CO_PUSH_HEAD;
            do_op = 1'b1;
            qcount_next[qidx] = n + CW'(1);
          end
        end
        CMD_POP_HEAD: begin
          if (n == '0) begin
            st = ST_EMPTY;
          end else begin
            op    = CO_CLOSE_AT;
            do_op = 1'b1;
            vout  = cdata[qidx][aidx];
            qcount_next[qidx] = n - CW'(1);
          end
        end
        CMD_REM_MATCH: begin
          if (!found) begin
            st = ST_NOT_FOUND;
          end else begin
            op    = CO_CLOSE_MATCH;
            do_op = 1'b1;
            vout  = val_r;
            qcount_next[qidx] = n - CW'(1);
          end
        end
        CMD_REM_AT: begin
          if (idx_x >= n_x) begin
            st = ST_RANGE;
          end else begin
            op    = CO_CLOSE_AT;
            do_op = 1'b1;
            vout  = cdata[qidx][aidx];
            qcount_next[qidx] = n - CW'(1);
          end
        end
        default: begin
          if (idx_x >= n_x) st = ST_RANGE;
          else vout = cdata[qidx][aidx];
        end
      endcase
    end
    // a failed claim reports queue 0 and its current count
    if (cmd_r == CMD_CLAIM) cnt_after = free_found ? '0 : qcount[0];
    else if (in_range) cnt_after = qcount_next[qidx];
    else cnt_after = '0;
  end

  always_comb begin
    for (int i = 0; i < NUM_QUEUES; i++) begin
      qctl[i].en = busy && do_op && (qidx == QW'(i)) && in_range;
      qctl[i].op = op;
    end
  end

  for (genvar gq = 0; gq < NUM_QUEUES; gq++) begin : g_row
    for (genvar gk = 0; gk < DEPTH; gk++) begin : g_cell
      logic [DATA_WIDTH-1:0] prev_d, next_d;
      logic                  hin;
      if (gk == 0) begin : g_first
        assign prev_d = val_r;
        assign hin    = 1'b0;
      end else begin : g_mid
        assign prev_d = cdata[gq][gk-1];
        assign hin    = chit[gq][gk-1];
      end
      if (gk == DEPTH - 1) begin : g_last
        assign next_d = '0;
      end else begin : g_inner
        assign next_d = cdata[gq][gk+1];
      end
      mqde_cell #(
        .DATA_WIDTH(DATA_WIDTH),
        .CW(CW),
        .XW(XW),
        .K(gk)
      ) u_cell (
        .clk(clk),
        .ctl(qctl[gq]),
        .val(val_r),
        .pos(pos_x),
        .cnt(qcount[gq]),
        .prev_data(prev_d),
        .next_data(next_d),
        .hit_in(hin),
        .data(cdata[gq][gk]),
        .hit_out(chit[gq][gk])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      done    <= 1'b0;
      claimed <= '0;
      for (int i = 0; i < NUM_QUEUES; i++) qcount[i] <= '0;
    end else begin
      done <= busy;
      if (busy) begin
        busy    <= 1'b0;
        claimed <= claimed_next;
        for (int i = 0; i < NUM_QUEUES; i++) qcount[i] <= qcount_next[i];
      end else if (start) begin
        busy <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_r <= cmd_e'(command);
      q_r   <= queue_id;
      val_r <= DATA_WIDTH'(value);
      idx_r <= index;
    end
    if (busy) begin
      status    <= st;
      value_out <= 32'(vout);
      queue_out <= qout;
      count     <= 5'(cnt_after);
    end
  end

endmodule

FILE: rtl/mqde_checker.sv
// port-level checker for the deque engine, bound to the top level
`include "multi_queue_deque_engine_core_assert.svh"

module mqde_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [2:0]  status,
  input logic [31:0] value_out,
  input logic [2:0]  queue_out,
  input logic [4:0]  count
);
  import mqde_pkg::*;

  `MQDE_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "accepted beat not busy")
  `MQDE_ASSERT_NEXT(a_busy_done, clk, rst, busy, done && !busy, "no result after work cycle")
  `MQDE_ASSERT_NOW(a_status_code, clk, rst, done, status <= 3'(ST_FULL), "bad status code")
  `MQDE_ASSERT_NOW(a_fail_zero, clk, rst, done && status != 3'(ST_OK), value_out == '0, "failed beat carries data")
  `MQDE_ASSERT_NOW(a_no_free, clk, rst, done && status == 3'(ST_NO_FREE), queue_out == '0, "no free result names a queue")

endmodule

bind multi_queue_deque_engine_core mqde_checker u_mqde_checker (.*);

FILE: test/multi_queue_deque_engine_core_test.sv
// testbench for the multi-queue deque engine: directed table, then random commands
`timescale 1ns / 100ps

module multi_queue_deque_engine_core_test;
  import mqde_pkg::*;

  localparam int NQ = NUM_QUEUES_DEF;
  localparam int DP = DEPTH_DEF;

  typedef struct {
    cmd_e        cmd;
    logic [2:0]  qid;
    logic [31:0] val;
    logic [3:0]  idx;
    bit          typed;
    status_e     st;
    logic [31:0] vout;
    logic [2:0]  qout;
    logic [4:0]  cnt;
  } cmd_row_t;

  typedef struct {
    status_e     st;
    logic [31:0] vout;
    logic [2:0]  qout;
    logic [4:0]  cnt;
  } reply_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic [2:0]  command = '0;
  logic [2:0]  queue_id = '0;
  logic [31:0] value = '0;
  logic [3:0]  index = '0;
  logic        busy, done;
  logic [2:0]  status, queue_out;
  logic [31:0] value_out;
  logic [4:0]  count;

  multi_queue_deque_engine_core dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // predictor state
  logic [31:0] words [NQ][DP];
  int          fill [NQ];
  bit          owned [NQ];

  reply_t replies_due [$];
  int     mismatches = 0;
  int     idle_pct = 0;

  function automatic reply_t apply_command(cmd_e c, logic [2:0] q, logic [31:0] v,
                                           logic [3:0] ix);
    reply_t r;
    int n;
    int hit;
    r.st = ST_OK;
    r.vout = '0;
    r.qout = q;
    if (c == CMD_CLAIM) begin
      r.qout = '0;
      r.st = ST_NO_FREE;
      for (int k = 0; k < NQ; k++) begin
        if (!owned[k]) begin
          owned[k] = 1;
          fill[k] = 0;
          r.qout = 3'(k);
          r.st = ST_OK;
          break;
        end
      end
    end else if (!owned[q]) begin
      r.st = ST_NOT_CLAIMED;
    end else begin
      n = fill[q];
      case (c)
        CMD_RELEASE: begin
          owned[q] = 0;
          fill[q] = 0;
        end
        CMD_PUSH_TAIL: begin
          if (n >= DP) r.st = ST_FULL;
          else begin
            words[q][n] = v;
            fill[q] = n + 1;
          end
        end
        CMD_PUSH_HEAD: begin
          if (n >= DP) r.st = ST_FULL;
          else begin
            for (int k = n; k > 0; k--) words[q][k] = words[q][k-1];
            words[q][0] = v;
            fill[q] = n + 1;
          end
        end
        CMD_POP_HEAD, CMD_REM_MATCH, CMD_REM_AT: begin
          hit = -1;
          if (c == CMD_POP_HEAD) begin
            if (n == 0) r.st = ST_EMPTY;
            else hit = 0;
          end else if (c == CMD_REM_AT) begin
            if (ix >= n) r.st = ST_RANGE;
            else hit = ix;
          end else begin
            for (int k = 0; k < n; k++) begin
              if (words[q][k] == v) begin
                hit = k;
                break;
              end
            end
            if (hit < 0) r.st = ST_NOT_FOUND;
          end
          if (hit >= 0) begin
            r.vout = words[q][hit];
            for (int k = hit; k + 1 < n; k++) words[q][k] = words[q][k+1];
            fill[q] = n - 1;
          end
        end
        default: begin
          if (ix >= n) r.st = ST_RANGE;
          else r.vout = words[q][ix];
        end
      endcase
    end
    r.cnt = 5'(fill[r.qout]);
    return r;
  endfunction

  task automatic issue(cmd_e c, logic [2:0] q, logic [31:0] v, logic [3:0] ix);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    command <= c;
    queue_id <= q;
    value <= v;
    index <= ix;
    @(posedge clk);
    while (busy) @(posedge clk);
    replies_due.push_back(apply_command(c, q, v, ix));
  endtask

  // check each result beat against the oldest prediction
  always @(posedge clk) begin
    if (!rst && done) begin
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat, status %0d", status);
      end else begin
        reply_t e;
        e = replies_due.pop_front();
        if (status !== e.st || value_out !== e.vout || queue_out !== e.qout ||
            count !== e.cnt) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st %0d val %h q %0d cnt %0d, got st %0d val %h q %0d cnt %0d",
                     e.st, e.vout, e.qout, e.cnt, status, value_out, queue_out, count);
        end
      end
    end
  end

  cmd_row_t rows [$];

  function automatic cmd_row_t mk(cmd_e c, logic [2:0] q, logic [31:0] v, logic [3:0] ix,
                                  bit typed = 0, status_e st = ST_OK,
                                  logic [31:0] vo = 0, logic [2:0] qo = 0,
                                  logic [4:0] cn = 0);
    cmd_row_t r;
    r.cmd = c; r.qid = q; r.val = v; r.idx = ix;
    r.typed = typed; r.st = st; r.vout = vo; r.qout = qo; r.cnt = cn;
    return r;
  endfunction

  // random command weighted toward claimed queues with short-lived content
  task automatic random_command();
    int   pick;
    logic [2:0] q;
    logic [31:0] v;
    cmd_e c;
    pick = $urandom_range(99);
    q = 3'($urandom_range(7));
    if ($urandom_range(9) < 8) begin
      for (int t = 0; t < 8; t++) begin
        if (owned[q]) break;
        q = 3'($urandom_range(7));
      end
    end
    if (pick < 6) c = CMD_CLAIM;
    else if (pick < 10) c = CMD_RELEASE;
    else if (pick < 35) c = CMD_PUSH_TAIL;
    else if (pick < 50) c = CMD_PUSH_HEAD;
    else if (pick < 62) c = CMD_POP_HEAD;
    else if (pick < 75) c = CMD_REM_MATCH;
    else if (pick < 86) c = CMD_REM_AT;
    else c = CMD_READ_AT;
    v = $urandom();
    if ($urandom_range(3) == 0) v = $urandom_range(3);
    if (c == CMD_REM_MATCH && fill[q] > 0 && $urandom_range(3) != 0)
      v = words[q][$urandom_range(fill[q] - 1)];
    issue(c, q, v, 4'($urandom_range(15)));
  endtask

  initial begin
    int drained;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // after reset, everything unclaimed
    rows.push_back(mk(CMD_PUSH_TAIL, 3, 32'h1, 0, 1, ST_NOT_CLAIMED, 0, 3, 0));
    rows.push_back(mk(CMD_READ_AT, 7, 0, 0, 1, ST_NOT_CLAIMED, 0, 7, 0));
    rows.push_back(mk(CMD_CLAIM, 5, 0, 0, 1, ST_OK, 0, 0, 0));
    rows.push_back(mk(CMD_POP_HEAD, 0, 0, 0, 1, ST_EMPTY, 0, 0, 0));
    rows.push_back(mk(CMD_REM_MATCH, 0, 0, 0, 1, ST_NOT_FOUND, 0, 0, 0));
    rows.push_back(mk(CMD_READ_AT, 0, 0, 0, 1, ST_RANGE, 0, 0, 0));
    rows.push_back(mk(CMD_PUSH_TAIL, 0, 32'hFFFF_FFFF, 0, 1, ST_OK, 0, 0, 1));
    rows.push_back(mk(CMD_PUSH_HEAD, 0, 32'h0, 0));
    rows.push_back(mk(CMD_PUSH_TAIL, 0, 32'hA5A5_5A5A, 0));
    rows.push_back(mk(CMD_READ_AT, 0, 0, 15, 1, ST_RANGE, 0, 0, 3));
    rows.push_back(mk(CMD_READ_AT, 0, 0, 1));
    rows.push_back(mk(CMD_REM_MATCH, 0, 32'hFFFF_FFFF, 0));
    rows.push_back(mk(CMD_REM_AT, 0, 0, 1));
    rows.push_back(mk(CMD_REM_AT, 0, 0, 4, 1, ST_RANGE, 0, 0, 1));
    rows.push_back(mk(CMD_POP_HEAD, 0, 0, 0));
    rows.push_back(mk(CMD_PUSH_TAIL, 0, 32'h7, 0));
    rows.push_back(mk(CMD_RELEASE, 0, 0, 0, 1, ST_OK, 0, 0, 0));
    rows.push_back(mk(CMD_RELEASE, 0, 0, 0, 1, ST_NOT_CLAIMED, 0, 0, 0));
    foreach (rows[i]) begin
      issue(rows[i].cmd, rows[i].qid, rows[i].val, rows[i].idx);
      if (rows[i].typed) begin
        replies_due[$].st = rows[i].st;
        replies_due[$].vout = rows[i].vout;
        replies_due[$].qout = rows[i].qout;
        replies_due[$].cnt = rows[i].cnt;
      end
    end
    // fill a queue to the top and claim every queue
    for (int k = 0; k < NQ + 1; k++) issue(CMD_CLAIM, 0, 0, 0);
    for (int k = 0; k < DP + 1; k++) issue(CMD_PUSH_TAIL, 2, $urandom(), 0);
    issue(CMD_PUSH_HEAD, 2, 32'h8000_0000, 0);
    issue(CMD_REM_AT, 2, 0, 15);
    issue(CMD_READ_AT, 2, 0, 14);
    for (int k = 0; k < NQ; k++) issue(CMD_RELEASE, 3'(k), 0, 0);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 0) ? 0 : (ph == 1) ? 48 : (ph == 2) ? 0 : 31;
      repeat (330) random_command();
    end
    @(posedge clk);
    start <= 0;
    drained = 0;
    while (replies_due.size() != 0 && drained < 1000) begin
      @(posedge clk);
      drained++;
    end
    repeat (4) @(posedge clk);
    if (mismatches == 0 && replies_due.size() == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
